### rtl/core/dcp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the DCP identify response parser.
// No dependencies; used by dcp_parse, dcp_rfifo and the top level.
package dcp_pkg;

  // frame layout
  localparam int MAX_FRAME_BYTES_DEF = 2048;
  localparam int MAC_FIRST     = 6;
  localparam int ETH_TYPE_HI   = 12;
  localparam int ETH_TYPE_LO   = 13;
  localparam int HDR_PLAIN     = 14;
  localparam int HDR_VLAN      = 18;
  localparam int DCP_HDR_BYTES = 12;

  localparam logic [15:0] ETH_VLAN   = 16'h8100;
  localparam logic [15:0] FRAME_ID   = 16'hFEFF;
  localparam logic [7:0]  SERVICE_ID = 8'h05;

  // option / suboption codes
  localparam logic [7:0] OPT_IP       = 8'h01;
  localparam logic [7:0] OPT_DEVICE   = 8'h02;
  localparam logic [7:0] IP_SUB_MAC   = 8'h01;
  localparam logic [7:0] IP_SUB_PARAM = 8'h02;
  localparam logic [7:0] DEV_SUB_TYPE = 8'h01;
  localparam logic [7:0] DEV_SUB_NAME = 8'h02;
  localparam logic [7:0] DEV_SUB_ID   = 8'h03;

  // result kinds
  localparam logic [1:0] KIND_TYPE    = 2'd0;
  localparam logic [1:0] KIND_NAME    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // status codes (frame check shares the same codes)
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_FRAME_ID = 2'd2;
  localparam logic [1:0] ST_SERVICE  = 2'd3;

  // found flag bits
  localparam int FND_IP   = 0;
  localparam int FND_TYPE = 1;
  localparam int FND_NAME = 2;
  localparam int FND_IDS  = 3;

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  text_byte;
    logic        text_block_end;
    logic [1:0]  status;
    logic [47:0] src_mac;
    logic [31:0] ip_addr;
    logic [31:0] subnet_mask;
    logic [31:0] gateway;
    logic [15:0] vendor_id;
    logic [15:0] device_id;
    logic [3:0]  found_flags;
    logic        is_last;
  } res_t;

  // results produced by one accepted beat: text first, then summary
  typedef struct packed {
    logic text_vld;
    logic sum_vld;
    res_t text;
    res_t sum;
  } push_t;

endpackage

### rtl/core/dcp_parse.sv
`timescale 1ns / 1ps
// Per-byte frame parser: header checks, option block walk, field capture.
// Depends on dcp_pkg.
module dcp_parse #(
  parameter int MAX_FRAME_BYTES = dcp_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      data_byte,
  input  logic            frame_end,
  output dcp_pkg::push_t  push
);

  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

  logic [PW-1:0]       pos, pos_next;
  logic                vlan, vlan_next;
  logic [15:0]         eth, eth_next;
  logic [47:0]         mac, mac_next;
  logic [1:0]          fc, fc_next;
  logic [15:0]         left, left_next;
  logic [31:0]         bhdr, bhdr_next;
  logic [16:0]         cnt, cnt_next;
  logic [2:0][31:0]    bval, bval_next;
  logic [31:0]         cfields, cfields_next;
  logic [2:0][31:0]    cip, cip_next;
  logic [3:0]          found, found_next;
  logic                walking, walking_next;

  always_comb begin
    logic [16:0] p17;
    logic [16:0] h17;
    logic [16:0] ha17;
    logic [3:0]  r4;
    logic [16:0] c;
    logic [15:0] blen;
    logic [16:0] vi;
    logic [16:0] adv;
    logic [16:0] total;
    logic [7:0]  opt;
    logic [7:0]  sub;
    logic [1:0]  k;
    logic [1:0]  st;

    pos_next     = pos;
    vlan_next    = vlan;
    eth_next     = eth;
    mac_next     = mac;
    fc_next      = fc;
    left_next    = left;
    bhdr_next    = bhdr;
    cnt_next     = cnt;
    bval_next    = bval;
    cfields_next = cfields;
    cip_next     = cip;
    found_next   = found;
    walking_next = walking;
    push         = '0;

    p17   = 17'(pos);
    h17   = vlan ? 17'(dcp_pkg::HDR_VLAN) : 17'(dcp_pkg::HDR_PLAIN);
    ha17  = '0;
    r4    = '0;
    c     = cnt;
    blen  = bhdr[15:0];
    vi    = '0;
    adv   = '0;
    total = '0;
    opt   = bhdr[31:24];
    sub   = bhdr[23:16];
    k     = '0;
    st    = '0;

    if (take) begin
      if (pos < PW'(MAX_FRAME_BYTES)) begin
        pos_next = pos + PW'(1);
        if (p17 >= 17'(dcp_pkg::MAC_FIRST) && p17 < 17'(dcp_pkg::ETH_TYPE_HI)) begin
          mac_next = {mac[39:0], data_byte};
        end
        if (p17 == 17'(dcp_pkg::ETH_TYPE_HI) || p17 == 17'(dcp_pkg::ETH_TYPE_LO)) begin
          eth_next = {eth[7:0], data_byte};
          if (p17 == 17'(dcp_pkg::ETH_TYPE_LO) && eth_next == dcp_pkg::ETH_VLAN) begin
            vlan_next = 1'b1;
          end
        end else if (p17 >= 17'(dcp_pkg::HDR_PLAIN)) begin
          if (p17 >= h17 && p17 < h17 + 17'(dcp_pkg::DCP_HDR_BYTES)) begin
            // DCP header: frame id, service id/type, xid, delay, data length
            r4 = 4'(p17 - h17);
            bhdr_next = {bhdr[23:0], data_byte};
            if (r4 == 4'd1 && bhdr_next[15:0] != dcp_pkg::FRAME_ID) begin
              fc_next = dcp_pkg::ST_FRAME_ID;
            end
            if (r4 == 4'd2 && fc == dcp_pkg::ST_OK && data_byte != dcp_pkg::SERVICE_ID) begin
              fc_next = dcp_pkg::ST_SERVICE;
            end
            if (r4 == 4'(dcp_pkg::DCP_HDR_BYTES - 1)) begin
              left_next    = bhdr_next[15:0];
              bhdr_next    = '0;
              cnt_next     = '0;
              walking_next = (fc == dcp_pkg::ST_OK) && (left_next >= 16'd4);
            end
          end else if (walking && p17 >= h17 + 17'(dcp_pkg::DCP_HDR_BYTES)) begin
            // option block walk
            if (c < 17'd4) begin
              bhdr_next = {bhdr[23:0], data_byte};
              if (c == 17'd3) begin
                blen = bhdr_next[15:0];
                adv  = 17'd4 + 17'(blen) + 17'(blen[0]);
                left_next = (adv > 17'(left)) ? '0 : 16'(17'(left) - adv);
                bval_next = '0;
              end
            end else begin
              vi = c - 17'd4;
              if (vi < 17'(blen)) begin
                if (vi >= 17'd2 && vi < 17'd14) begin
                  k = 2'((vi - 17'd2) >> 2);
                  bval_next[k] = {bval[k][23:0], data_byte};
                end
                if (opt == dcp_pkg::OPT_DEVICE && blen > 16'd2 && vi >= 17'd2 &&
                    (sub == dcp_pkg::DEV_SUB_TYPE || sub == dcp_pkg::DEV_SUB_NAME)) begin
                  push.text_vld = 1'b1;
                  push.text.kind = (sub == dcp_pkg::DEV_SUB_TYPE) ? dcp_pkg::KIND_TYPE
                                                                 : dcp_pkg::KIND_NAME;
                  push.text.text_byte      = data_byte;
                  push.text.text_block_end = (vi == 17'(blen) - 17'd1);
                end
                if (vi == 17'(blen) - 17'd1) begin
                  if (opt == dcp_pkg::OPT_IP && blen >= 16'd14 &&
                      (sub == dcp_pkg::IP_SUB_MAC || sub == dcp_pkg::IP_SUB_PARAM)) begin
                    cip_next = bval_next;
                    found_next[dcp_pkg::FND_IP] = 1'b1;
                  end else if (opt == dcp_pkg::OPT_DEVICE && sub == dcp_pkg::DEV_SUB_TYPE &&
                               blen > 16'd2) begin
                    found_next[dcp_pkg::FND_TYPE] = 1'b1;
                  end else if (opt == dcp_pkg::OPT_DEVICE && sub == dcp_pkg::DEV_SUB_NAME &&
                               blen > 16'd2) begin
                    found_next[dcp_pkg::FND_NAME] = 1'b1;
                  end else if (opt == dcp_pkg::OPT_DEVICE && sub == dcp_pkg::DEV_SUB_ID &&
                               blen == 16'd6) begin
                    cfields_next = bval_next[0];
                    found_next[dcp_pkg::FND_IDS] = 1'b1;
                  end
                end
              end
            end
            cnt_next = c + 17'd1;
            if (c >= 17'd3) begin
              blen  = bhdr_next[15:0];
              total = 17'd4 + 17'(blen) + 17'(blen[0]);
              if (cnt_next >= total) begin
                if (left_next >= 16'd4) begin
                  cnt_next  = '0;
                  bhdr_next = '0;
                end else begin
                  walking_next = 1'b0;
                end
              end
            end
          end
        end
      end

      if (frame_end) begin
        ha17 = vlan_next ? 17'(dcp_pkg::HDR_VLAN) : 17'(dcp_pkg::HDR_PLAIN);
        st = (17'(pos_next) < ha17 + 17'(dcp_pkg::DCP_HDR_BYTES)) ? dcp_pkg::ST_SHORT : fc_next;
        push.sum_vld     = 1'b1;
        push.sum.kind    = dcp_pkg::KIND_SUMMARY;
        push.sum.status  = st;
        push.sum.is_last = 1'b1;
        if (st == dcp_pkg::ST_OK) begin
          push.sum.src_mac     = mac_next;
          push.sum.ip_addr     = cip_next[0];
          push.sum.subnet_mask = cip_next[1];
          push.sum.gateway     = cip_next[2];
          push.sum.vendor_id   = cfields_next[31:16];
          push.sum.device_id   = cfields_next[15:0];
          push.sum.found_flags = found_next;
        end
        // start over for the next frame
        pos_next     = '0;
        vlan_next    = 1'b0;
        eth_next     = '0;
        mac_next     = '0;
        fc_next      = dcp_pkg::ST_OK;
        left_next    = '0;
        bhdr_next    = '0;
        cnt_next     = '0;
        bval_next    = '0;
        cfields_next = '0;
        cip_next     = '0;
        found_next   = '0;
        walking_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      vlan    <= 1'b0;
      eth     <= '0;
      mac     <= '0;
      fc      <= dcp_pkg::ST_OK;
      left    <= '0;
      bhdr    <= '0;
      cnt     <= '0;
      bval    <= '0;
      cfields <= '0;
      cip     <= '0;
      found   <= '0;
      walking <= 1'b0;
    end else begin
      pos     <= pos_next;
      vlan    <= vlan_next;
      eth     <= eth_next;
      mac     <= mac_next;
      fc      <= fc_next;
      left    <= left_next;
      bhdr    <= bhdr_next;
      cnt     <= cnt_next;
      bval    <= bval_next;
      cfields <= cfields_next;
      cip     <= cip_next;
      found   <= found_next;
      walking <= walking_next;
    end
  end

  // an accepted frame end always leaves the parser at the start of a fresh frame
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    take && frame_end |=> pos == '0 && !walking && found == '0)
    else $error("parser state not cleared after frame end");

  // text only comes out of an active block walk
  a_text_walk: assert property (@(posedge clk) disable iff (rst)
    push.text_vld |-> walking && take)
    else $error("text result outside block walk");

endmodule

### rtl/core/dcp_rfifo.sv
`timescale 1ns / 1ps
// Small result queue: takes up to two results a cycle, hands out one when out_ready is high.
// Depends on dcp_pkg.
module dcp_rfifo (
  input  logic                          clk,
  input  logic                          rst,
  input  dcp_pkg::push_t                push,
  output logic                          room,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dcp_pkg::res_t                 out_item
);

  dcp_pkg::res_t                 mem [dcp_pkg::RQ_DEPTH];
  logic [dcp_pkg::RQ_AW-1:0]     wptr, rptr;
  logic [dcp_pkg::RQ_CW-1:0]     count, count_next;
  logic [dcp_pkg::RQ_AW-1:0]     sum_addr;
  logic                          pop;
  logic [1:0]                    n_push;

  assign pop       = out_valid && out_ready;
  assign n_push    = 2'(push.text_vld) + 2'(push.sum_vld);
  assign sum_addr  = wptr + dcp_pkg::RQ_AW'(push.text_vld);
  assign room      = count <= dcp_pkg::RQ_CW'(dcp_pkg::RQ_DEPTH - 2);
  assign out_valid = count != '0;
  assign out_item  = mem[rptr];
  assign count_next = count + dcp_pkg::RQ_CW'(n_push) - dcp_pkg::RQ_CW'(pop);

  always_ff @(posedge clk) begin
    if (push.text_vld) begin
      mem[wptr] <= push.text;
    end
    if (push.sum_vld) begin
      mem[sum_addr] <= push.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + dcp_pkg::RQ_AW'(n_push);
      rptr  <= rptr + dcp_pkg::RQ_AW'(pop);
      count <= count_next;
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst)
    count <= dcp_pkg::RQ_CW'(dcp_pkg::RQ_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.text_vld || push.sum_vld) |-> count <= dcp_pkg::RQ_CW'(dcp_pkg::RQ_DEPTH - 2))
    else $error("push without room for a full beat");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    pop && !push.text_vld && !push.sum_vld |=> count == $past(count) - dcp_pkg::RQ_CW'(1))
    else $error("queue count wrong after pop");

endmodule

### rtl/core/dcp_identify_response_parser_top.sv
`timescale 1ns / 1ps
// Top level of the DCP identify response parser.
// Depends on dcp_pkg, dcp_parse and dcp_rfifo.
//
// Usage:
//   Slave side (s_*) carries the received Ethernet frame one byte per beat,
//   s_tlast on the last byte of the frame. Master side (m_*) carries results:
//   station type / name payload bytes (m_tuser = 0 / 1) as they arrive, each
//   block closed by text_block_end, and one summary beat (m_tuser = 2,
//   m_tlast = 1) per frame with status, source MAC, IP block values,
//   vendor / device id and found flags.
//   Throughput: one byte per cycle while s_tready is high. Each accepted
//   beat is parsed in the cycle it is taken; the state registers and the
//   result queue load at that edge, and a result shows on m_tvalid once the
//   entries ahead of it have drained. A last byte that also carries a text
//   byte gives two results; the queue drains one per cycle while m_tready is high.
//   Stall: the 4-entry result queue parts the two sides. s_tready stays high
//   while at least two entries are free, so the input keeps flowing while a
//   result waits on m_tready; a longer stall fills the queue and holds off
//   the input until beats are taken again.
//   Reset (rst, synchronous): clears the frame state and empties the queue.
module dcp_identify_response_parser_top #(
  parameter int MAX_FRAME_BYTES = dcp_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] data_byte
  input  logic          s_tlast,   // frame_end
  output logic          m_tvalid,
  input  logic          m_tready,
  // [7:0] text_byte, [8] text_block_end, [10:9] status, [58:11] src_mac,
  // [90:59] ip_addr, [122:91] subnet_mask, [154:123] gateway,
  // [170:155] vendor_id, [186:171] device_id, [190:187] found_flags, [191] zero
  output logic [191:0]  m_tdata,
  output logic [1:0]    m_tuser,   // [1:0] kind
  output logic          m_tlast    // is_last
);

  dcp_pkg::push_t push;
  dcp_pkg::res_t  item;
  logic           take;
  logic           room;

  assign s_tready = room;
  assign take     = s_tvalid && s_tready;

  dcp_parse #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (s_tdata),
    .frame_end (s_tlast),
    .push      (push)
  );

  dcp_rfifo u_rfifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (item)
  );

  assign m_tuser = item.kind;
  assign m_tlast = item.is_last;
  assign m_tdata = {1'b0, item.found_flags, item.device_id, item.vendor_id, item.gateway,
                    item.subnet_mask, item.ip_addr, item.src_mac, item.status,
                    item.text_block_end, item.text_byte};

endmodule

### test/tb_dcp_identify_response_parser_top.sv
`timescale 1ns / 1ps
// Self-checking bench for dcp_identify_response_parser_top: byte-stream frames in,
// type/name text beats and per-frame summaries out, checked against a local predictor.
// Depends on dcp_pkg and the RTL of the parser only.
module tb_dcp_identify_response_parser_top;
  import dcp_pkg::*;

  localparam int FRAME_CAP   = MAX_FRAME_BYTES_DEF;
  localparam int IP_BLK_LEN  = 14;
  localparam int ID_BLK_LEN  = 6;
  localparam int BLK_HDR_LEN = 4;
  localparam logic [15:0] ETH_PNIO = 16'h8892;
  localparam int RAND_BEATS  = 200;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 20;

  typedef logic [7:0] byte_q_t[$];

  // Frame parser mirror plus the queue of result beats it predicts.
  class parse_board;
    res_t results_due[$];
    int errs;
    int pos, hdr_off, dcp_left, blk_cnt;
    logic [15:0] eth_type;
    logic [47:0] mac;
    logic [1:0] fcheck;
    logic [31:0] blk_hdr, ids;
    logic [2:0][31:0] blk_val, ip;
    logic [3:0] found;
    bit walking;

    function new();
      errs = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos = 0;
      hdr_off = HDR_PLAIN;
      eth_type = '0;
      mac = '0;
      fcheck = ST_OK;
      dcp_left = 0;
      blk_hdr = '0;
      blk_cnt = 0;
      blk_val = '0;
      ids = '0;
      ip = '0;
      found = '0;
      walking = 0;
    endfunction

    function void add_text(logic [1:0] kind, logic [7:0] b, logic done);
      res_t r;
      r = '0;
      r.kind = kind;
      r.text_byte = b;
      r.text_block_end = done;
      results_due.push_back(r);
    endfunction

    // One byte inside the option block area.
    function void walk(logic [7:0] b);
      int c, blen, vi, adv, tot;
      logic [7:0] opt, sub;
      c = blk_cnt;
      blen = int'(blk_hdr[15:0]);
      if (c < BLK_HDR_LEN) begin
        blk_hdr = {blk_hdr[23:0], b};
        if (c == BLK_HDR_LEN - 1) begin
          blen = int'(blk_hdr[15:0]);
          adv = BLK_HDR_LEN + blen + (blen & 1);
          dcp_left = (adv > dcp_left) ? 0 : dcp_left - adv;
          blk_val = '0;
        end
      end else begin
        opt = blk_hdr[31:24];
        sub = blk_hdr[23:16];
        vi = c - BLK_HDR_LEN;
        if (vi < blen) begin
          if (vi >= 2 && vi < IP_BLK_LEN)
            blk_val[(vi - 2) >> 2] = {blk_val[(vi - 2) >> 2][23:0], b};
          if (opt == OPT_DEVICE && (sub == DEV_SUB_TYPE || sub == DEV_SUB_NAME) &&
              blen > 2 && vi >= 2)
            add_text((sub == DEV_SUB_TYPE) ? KIND_TYPE : KIND_NAME, b, vi == blen - 1);
          if (vi == blen - 1) begin
            if (opt == OPT_IP && (sub == IP_SUB_MAC || sub == IP_SUB_PARAM) &&
                blen >= IP_BLK_LEN) begin
              ip = blk_val;
              found[FND_IP] = 1'b1;
            end else if (opt == OPT_DEVICE && sub == DEV_SUB_TYPE && blen > 2) begin
              found[FND_TYPE] = 1'b1;
            end else if (opt == OPT_DEVICE && sub == DEV_SUB_NAME && blen > 2) begin
              found[FND_NAME] = 1'b1;
            end else if (opt == OPT_DEVICE && sub == DEV_SUB_ID && blen == ID_BLK_LEN) begin
              ids = blk_val[0];
              found[FND_IDS] = 1'b1;
            end
          end
        end
      end
      blk_cnt = c + 1;
      if (c >= BLK_HDR_LEN - 1) begin
        blen = int'(blk_hdr[15:0]);
        tot = BLK_HDR_LEN + blen + (blen & 1);
        if (blk_cnt >= tot) begin
          if (dcp_left >= BLK_HDR_LEN) begin
            blk_cnt = 0;
            blk_hdr = '0;
          end else begin
            walking = 0;
          end
        end
      end
    endfunction

    function void take(int p, logic [7:0] b);
      int hb;
      if (p >= MAC_FIRST && p < ETH_TYPE_HI)
        mac = {mac[39:0], b};
      if (p == ETH_TYPE_HI || p == ETH_TYPE_LO) begin
        eth_type = {eth_type[7:0], b};
        if (p == ETH_TYPE_LO && eth_type == ETH_VLAN)
          hdr_off = HDR_VLAN;
        return;
      end
      if (p < HDR_PLAIN)
        return;
      if (p >= hdr_off && p < hdr_off + DCP_HDR_BYTES) begin
        hb = p - hdr_off;
        blk_hdr = {blk_hdr[23:0], b};
        if (hb == 1 && blk_hdr[15:0] != FRAME_ID)
          fcheck = ST_FRAME_ID;
        if (hb == 2 && fcheck == ST_OK && b != SERVICE_ID)
          fcheck = ST_SERVICE;
        if (hb == DCP_HDR_BYTES - 1) begin
          dcp_left = int'(blk_hdr[15:0]);
          blk_hdr = '0;
          blk_cnt = 0;
          walking = (fcheck == ST_OK && dcp_left >= BLK_HDR_LEN);
        end
      end else if (walking && p >= hdr_off + DCP_HDR_BYTES) begin
        walk(b);
      end
    endfunction

    // Accepted input beat.
    function void note_beat(logic [7:0] b, logic last);
      res_t r;
      logic [1:0] st;
      if (pos < FRAME_CAP) begin
        pos++;
        take(pos - 1, b);
      end
      if (last) begin
        st = (pos < hdr_off + DCP_HDR_BYTES) ? ST_SHORT : fcheck;
        r = '0;
        r.kind = KIND_SUMMARY;
        r.status = st;
        if (st == ST_OK) begin
          r.src_mac = mac;
          r.ip_addr = ip[0];
          r.subnet_mask = ip[1];
          r.gateway = ip[2];
          r.vendor_id = ids[31:16];
          r.device_id = ids[15:0];
          r.found_flags = found;
        end
        r.is_last = 1'b1;
        results_due.push_back(r);
        clear_frame();
      end
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errs++;
      end
    endfunction

    // Accepted output beat against the oldest prediction.
    function void match_beat(res_t got);
      res_t want;
      if (results_due.size() == 0) begin
        $error("result beat with nothing due: kind %0d", got.kind);
        errs++;
        return;
      end
      want = results_due.pop_front();
      cmp("kind", want.kind, got.kind);
      cmp("text_byte", want.text_byte, got.text_byte);
      cmp("text_block_end", want.text_block_end, got.text_block_end);
      cmp("status", want.status, got.status);
      cmp("src_mac", want.src_mac, got.src_mac);
      cmp("ip_addr", want.ip_addr, got.ip_addr);
      cmp("subnet_mask", want.subnet_mask, got.subnet_mask);
      cmp("gateway", want.gateway, got.gateway);
      cmp("vendor_id", want.vendor_id, got.vendor_id);
      cmp("device_id", want.device_id, got.device_id);
      cmp("found_flags", want.found_flags, got.found_flags);
      cmp("is_last", want.is_last, got.is_last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [7:0] s_tdata;     // [7:0] data_byte
  logic s_tlast;           // frame_end
  logic m_tvalid;
  logic m_tready;
  // [7:0] text_byte, [8] text_block_end, [10:9] status, [58:11] src_mac,
  // [90:59] ip_addr, [122:91] subnet_mask, [154:123] gateway,
  // [170:155] vendor_id, [186:171] device_id, [190:187] found_flags, [191] zero
  logic [191:0] m_tdata;
  logic [1:0] m_tuser;     // [1:0] kind
  logic m_tlast;           // is_last

  parse_board board = new();
  byte_q_t frame_q, opt_q;
  bit calm = 0;            // no idling on either side while set
  int beats_sent = 0;
  int quiet = 0;
  int rand_start;

  always #5 clk = ~clk;

  dcp_identify_response_parser_top #(
    .MAX_FRAME_BYTES(FRAME_CAP)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // Sink side backpressure, changed on the falling edge.
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 35);
  end

  // Both handshakes sampled at the rising edge; the input beat is noted first.
  always @(posedge clk) begin : port_watch
    res_t got;
    if (!rst) begin
      if (s_tvalid && s_tready)
        board.note_beat(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.text_byte = m_tdata[7:0];
        got.text_block_end = m_tdata[8];
        got.status = m_tdata[10:9];
        got.src_mac = m_tdata[58:11];
        got.ip_addr = m_tdata[90:59];
        got.subnet_mask = m_tdata[122:91];
        got.gateway = m_tdata[154:123];
        got.vendor_id = m_tdata[170:155];
        got.device_id = m_tdata[186:171];
        got.found_flags = m_tdata[190:187];
        got.is_last = m_tlast;
        board.match_beat(got);
      end
    end
  end

  // Watchdog: too long without a beat on either side means the block hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("tb_dcp_identify_response_parser_top: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic void put_rand(ref byte_q_t q, input int n);
    repeat (n) q.push_back(8'($urandom));
  endfunction

  // Option block: header, random block info and payload, pad to even size.
  function automatic void put_block(logic [7:0] opt, logic [7:0] sub, int len);
    logic [15:0] l16;
    l16 = 16'(len);
    opt_q.push_back(opt);
    opt_q.push_back(sub);
    opt_q.push_back(l16[15:8]);
    opt_q.push_back(l16[7:0]);
    put_rand(opt_q, len + (len & 1));
  endfunction

  // Called on a falling edge, returns on the falling edge after the beat is taken.
  task automatic send_beat(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < 35) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'($urandom);
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_beat(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  // Ethernet + DCP header around opt_q, then tail bytes; keep > 0 cuts the frame.
  task automatic ship(bit vlan, logic [15:0] fid, logic [7:0] sid, logic [15:0] dlen,
                      int tail, int keep);
    put_rand(frame_q, 12);
    if (vlan) begin
      frame_q.push_back(ETH_VLAN[15:8]);
      frame_q.push_back(ETH_VLAN[7:0]);
      put_rand(frame_q, 2);
    end
    frame_q.push_back(ETH_PNIO[15:8]);
    frame_q.push_back(ETH_PNIO[7:0]);
    frame_q.push_back(fid[15:8]);
    frame_q.push_back(fid[7:0]);
    frame_q.push_back(sid);
    put_rand(frame_q, 7);       // service type, xid, response delay
    frame_q.push_back(dlen[15:8]);
    frame_q.push_back(dlen[7:0]);
    frame_q = {frame_q, opt_q};
    opt_q.delete();
    put_rand(frame_q, tail);
    if (keep > 0 && keep < frame_q.size())
      frame_q = frame_q[0:keep - 1];
    send_frame();
  endtask

  // Mostly well-formed responses with random content; some bent on purpose.
  task automatic random_frame();
    int nblk, pick, dlen, keep, tail;
    bit vlan;
    logic [15:0] fid;
    logic [7:0] sid;
    nblk = $urandom_range(0, 4);
    repeat (nblk) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1: put_block(OPT_IP, 8'($urandom_range(1, 2)),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(10, 17) : IP_BLK_LEN);
        2: put_block(OPT_DEVICE, DEV_SUB_ID,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : ID_BLK_LEN);
        3, 4: put_block(OPT_DEVICE, DEV_SUB_TYPE, $urandom_range(0, 10));
        5, 6: put_block(OPT_DEVICE, DEV_SUB_NAME, $urandom_range(0, 14));
        default: put_block(8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
                           $urandom_range(0, 8));
      endcase
    end
    dlen = opt_q.size();
    pick = $urandom_range(0, 19);
    if (pick == 0)
      dlen = $urandom_range(0, 3);
    else if (pick == 1)
      dlen = $urandom_range(0, dlen);
    else if (pick == 2)
      dlen = dlen + $urandom_range(1, 40);
    fid = ($urandom_range(0, 19) == 0) ? 16'($urandom) : FRAME_ID;
    sid = ($urandom_range(0, 19) == 0) ? 8'($urandom) : SERVICE_ID;
    vlan = ($urandom_range(0, 9) < 3);
    tail = $urandom_range(0, 3);
    keep = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30 + opt_q.size() + tail) : 0;
    ship(vlan, fid, sid, 16'(dlen), tail, keep);
  endtask

  initial begin
    int n;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // the IP parameter block and every device block kind in one accepted frame
    put_block(OPT_IP, IP_SUB_PARAM, IP_BLK_LEN);
    put_block(OPT_DEVICE, DEV_SUB_TYPE, 9);
    put_block(OPT_DEVICE, DEV_SUB_NAME, 12);
    put_block(OPT_DEVICE, DEV_SUB_ID, ID_BLK_LEN);
    ship(0, FRAME_ID, SERVICE_ID, 16'(opt_q.size()), 0, 0);
    // VLAN tagged, trailing bytes past the data length
    put_block(OPT_IP, IP_SUB_MAC, IP_BLK_LEN);
    put_block(OPT_DEVICE, DEV_SUB_ID, ID_BLK_LEN);
    ship(1, FRAME_ID, SERVICE_ID, 16'(opt_q.size()), 4, 0);
    // rejected frames stream nothing: bad frame id, bad service id, both
    put_block(OPT_DEVICE, DEV_SUB_NAME, 6);
    ship(0, ~FRAME_ID, SERVICE_ID, 16'(opt_q.size()), 0, 0);
    put_block(OPT_DEVICE, DEV_SUB_NAME, 6);
    ship(0, FRAME_ID, ~SERVICE_ID, 16'(opt_q.size()), 0, 0);
    ship(1, ~FRAME_ID, ~SERVICE_ID, 0, 2, 0);
    // too short, one byte under the header end; then exactly long enough
    ship(0, FRAME_ID, SERVICE_ID, 0, 0, HDR_PLAIN + DCP_HDR_BYTES - 1);
    ship(0, FRAME_ID, SERVICE_ID, 0, 0, 0);
    // too short beats a bad frame id; VLAN moves the limit
    ship(1, ~FRAME_ID, SERVICE_ID, 0, 0, HDR_VLAN + DCP_HDR_BYTES - 1);
    // single-byte frame
    ship(0, FRAME_ID, SERVICE_ID, 0, 0, 1);
    // repeated blocks: the last complete one wins
    put_block(OPT_IP, IP_SUB_MAC, IP_BLK_LEN);
    put_block(OPT_IP, IP_SUB_PARAM, IP_BLK_LEN);
    put_block(OPT_DEVICE, DEV_SUB_ID, ID_BLK_LEN);
    put_block(OPT_DEVICE, DEV_SUB_ID, ID_BLK_LEN);
    ship(0, FRAME_ID, SERVICE_ID, 16'(opt_q.size()), 0, 0);
    // IP block cut off by frame end is not committed
    put_block(OPT_IP, IP_SUB_PARAM, IP_BLK_LEN);
    put_block(OPT_DEVICE, DEV_SUB_NAME, 10);
    put_block(OPT_IP, IP_SUB_MAC, IP_BLK_LEN);
    n = HDR_PLAIN + DCP_HDR_BYTES + opt_q.size();
    ship(0, FRAME_ID, SERVICE_ID, 16'(opt_q.size()), 0, n - 6);
    // name run cut mid-payload: no block end
    put_block(OPT_DEVICE, DEV_SUB_NAME, 10);
    n = HDR_PLAIN + DCP_HDR_BYTES + opt_q.size();
    ship(0, FRAME_ID, SERVICE_ID, 16'(opt_q.size()), 0, n - 3);
    // odd name block, pad byte missing: block end lands on frame end
    put_block(OPT_DEVICE, DEV_SUB_TYPE, 4);
    put_block(OPT_DEVICE, DEV_SUB_NAME, 5);
    n = HDR_VLAN + DCP_HDR_BYTES + opt_q.size();
    ship(1, FRAME_ID, SERVICE_ID, 16'(opt_q.size()), 0, n - 1);
    // data length overrun: walk stops after the first block
    put_block(OPT_IP, IP_SUB_PARAM, IP_BLK_LEN);
    put_block(OPT_DEVICE, DEV_SUB_TYPE, 5);
    put_block(OPT_DEVICE, DEV_SUB_NAME, 6);
    ship(0, FRAME_ID, SERVICE_ID, 10, 0, 0);
    // empty and one-byte text blocks
    put_block(OPT_DEVICE, DEV_SUB_TYPE, 0);
    put_block(OPT_DEVICE, DEV_SUB_NAME, 1);
    put_block(OPT_DEVICE, DEV_SUB_TYPE, 2);
    put_block(OPT_DEVICE, DEV_SUB_NAME, 2);
    put_block(OPT_DEVICE, DEV_SUB_TYPE, 3);
    ship(0, FRAME_ID, SERVICE_ID, 16'(opt_q.size()), 1, 0);
    // data length below one block header: nothing walked
    put_block(OPT_DEVICE, DEV_SUB_NAME, 6);
    ship(0, FRAME_ID, SERVICE_ID, 3, 0, 0);
    // wrong sizes and unknown options are walked over
    put_block(OPT_IP, IP_SUB_PARAM, 12);
    put_block(OPT_DEVICE, DEV_SUB_ID, 8);
    put_block(8'hFF, 8'hFF, 3);
    put_block(OPT_DEVICE, 8'h04, 4);
    put_block(OPT_IP, IP_SUB_MAC, 16);
    ship(0, FRAME_ID, SERVICE_ID, 16'hFFFF, 3, 0);
    // maximum block length, never completes
    opt_q = {OPT_DEVICE, DEV_SUB_NAME, 8'hFF, 8'hFF};
    put_rand(opt_q, 30);
    ship(0, FRAME_ID, SERVICE_ID, 16'hFFFF, 0, 0);
    // all-zero and all-ones frames
    repeat (30) frame_q.push_back(8'h00);
    send_frame();
    repeat (30) frame_q.push_back(8'hFF);
    send_frame();

    // random part, with one stretch where neither side idles
    rand_start = beats_sent;
    while (beats_sent - rand_start < RAND_BEATS) begin
      n = beats_sent - rand_start;
      calm = (n >= 40 && n < 160);
      if ($urandom_range(99) < 20) begin
        put_rand(frame_q, $urandom_range(1, 40));
        send_frame();
      end else begin
        random_frame();
      end
    end
    calm = 0;
    s_tvalid <= 1'b0;

    while (board.results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.errs == 0 && board.results_due.size() == 0)
      $display("tb_dcp_identify_response_parser_top: PASS");
    else
      $display("tb_dcp_identify_response_parser_top: FAIL");
    $finish;
  end

endmodule

### dcp_identify_response_parser_top.f
rtl/core/dcp_pkg.sv
rtl/core/dcp_parse.sv
rtl/core/dcp_rfifo.sv
rtl/core/dcp_identify_response_parser_top.sv
test/tb_dcp_identify_response_parser_top.sv
